/* sv/msc_pkg.sv */
// Package with shared constants and types for the magic square checker.
`default_nettype none

package msc_pkg;

    localparam int DEF_MAX_ORDER   = 16;
    localparam int DEF_VALUE_WIDTH = 16;
    localparam int ORDER_WIDTH     = 5;
    localparam int ORDER_RESET     = 3;
    localparam int SUM_OUT_WIDTH   = 20;

    // Position flags of one element within its matrix.
    typedef struct packed {
        logic first_col;
        logic first_row;
        logic last_col;
        logic last_row;
        logic on_main;
        logic on_anti;
    } pos_flags_t;

endpackage

`default_nettype wire

/* sv/msc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module msc_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                     wr_data,
    input  wire logic                                 rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* sv/magic_square_check.sv */
// Magic square checker: one element per cycle, one verdict per matrix.
// Throughput: one element per cycle; the column-sum RAM read-modify-write
// spans two stages with forwarding between them.
// The last element passes through stage 1 into the output register, which holds the
// verdict. A full output register stalls only the last element.
// Reset: synchronous, active low; order returns to 3, position to (0,0).
// The column-sum RAM needs no clearing pass; the first row writes it.
`default_nettype none

module magic_square_check #(
    parameter int MAX_ORDER   = msc_pkg::DEF_MAX_ORDER,
    parameter int VALUE_WIDTH = msc_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [msc_pkg::ORDER_WIDTH-1:0]        cfg_wr_data,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic signed [VALUE_WIDTH-1:0]          s_element_value,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic                                        m_is_magic,
    output logic signed [msc_pkg::SUM_OUT_WIDTH-1:0]    m_magic_sum
);

    import msc_pkg::*;

    localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int ACC_W = VALUE_WIDTH + ((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 0);
    localparam int CNT_W = ($clog2(MAX_ORDER + 1) > ORDER_WIDTH) ?
                           $clog2(MAX_ORDER + 1) : ORDER_WIDTH;
    localparam int EXT_W = (ACC_W > SUM_OUT_WIDTH) ? ACC_W : SUM_OUT_WIDTH;

    // Configuration and position.
    logic [ORDER_WIDTH-1:0] order_reg;
    logic [IDX_W-1:0]       row_reg, row_next;
    logic [IDX_W-1:0]       col_reg, col_next;

    logic [CNT_W-1:0] order_ext, order_eff, order_m1;
    logic [IDX_W-1:0] last_idx;
    pos_flags_t       pos_flags;

    always_comb begin
        order_ext = CNT_W'(order_reg);
        if (order_ext == '0) begin
            order_eff = CNT_W'(1);
        end else if (order_ext > CNT_W'(MAX_ORDER)) begin
            order_eff = CNT_W'(MAX_ORDER);
        end else begin
            order_eff = order_ext;
        end
        order_m1 = order_eff - CNT_W'(1);
        last_idx = order_m1[IDX_W-1:0];

        pos_flags.first_col = (col_reg == '0);
        pos_flags.first_row = (row_reg == '0);
        pos_flags.last_col  = (col_reg == last_idx);
        pos_flags.last_row  = (row_reg == last_idx);
        pos_flags.on_main   = (row_reg == col_reg);
        pos_flags.on_anti   = (col_reg == last_idx - row_reg);
    end

    // Stage 1 registers.
    logic                    s1_valid_reg, s1_valid_next;
    pos_flags_t              s1_flags_reg;
    logic [IDX_W-1:0]        s1_col_reg;
    logic signed [ACC_W-1:0] s1_value_reg;
    logic                    fwd_reg;
    logic signed [ACC_W-1:0] fwd_data_reg;

    // Accumulators.
    logic signed [ACC_W-1:0] row_sum_reg, row_sum_next;
    logic signed [ACC_W-1:0] target_reg, target_next;
    logic signed [ACC_W-1:0] main_sum_reg, main_sum_next;
    logic signed [ACC_W-1:0] anti_sum_reg, anti_sum_next;
    logic                    mismatch_reg, mismatch_next;

    // Output register.
    logic                              m_valid_reg, m_valid_next;
    logic                              m_is_magic_reg;
    logic signed [SUM_OUT_WIDTH-1:0]   m_magic_sum_reg;

    logic s_accept, s1_fire, s1_last;

    logic signed [ACC_W-1:0] ram_rdata;
    logic signed [ACC_W-1:0] col_old, col_new;
    logic signed [ACC_W-1:0] main_base, anti_base;
    logic                    mismatch_base;
    logic signed [EXT_W-1:0] target_ext;

    assign s1_last  = s1_flags_reg.last_col && s1_flags_reg.last_row;
    assign s1_fire  = s1_valid_reg && (!s1_last || !m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_fire;
    assign s_accept = s_valid && s_ready;

    msc_ram #(
        .WIDTH(ACC_W),
        .DEPTH(MAX_ORDER)
    ) u_col_ram (
        .aclk    (aclk),
        .wr_en   (s1_fire),
        .wr_addr (s1_col_reg),
        .wr_data (col_new),
        .rd_en   (s_accept),
        .rd_addr (col_reg),
        .rd_data (ram_rdata)
    );

    always_comb begin
        col_old = fwd_reg ? fwd_data_reg : ram_rdata;
        col_new = s1_flags_reg.first_row ? s1_value_reg : col_old + s1_value_reg;

        row_sum_next = s1_flags_reg.first_col ? s1_value_reg : row_sum_reg + s1_value_reg;

        // Element (0,0) opens a new matrix and restarts the diagonals and the mismatch flag.
        main_base     = (s1_flags_reg.first_col && s1_flags_reg.first_row) ? '0 : main_sum_reg;
        anti_base     = (s1_flags_reg.first_col && s1_flags_reg.first_row) ? '0 : anti_sum_reg;
        mismatch_base = (s1_flags_reg.first_col && s1_flags_reg.first_row) ? 1'b0 : mismatch_reg;

        main_sum_next = s1_flags_reg.on_main ? main_base + s1_value_reg : main_base;
        anti_sum_next = s1_flags_reg.on_anti ? anti_base + s1_value_reg : anti_base;

        target_next = (s1_flags_reg.last_col && s1_flags_reg.first_row) ?
                      row_sum_next : target_reg;

        mismatch_next = mismatch_base;
        if (s1_flags_reg.last_col && !s1_flags_reg.first_row && row_sum_next != target_reg) begin
            mismatch_next = 1'b1;
        end
        if (s1_flags_reg.last_row && col_new != target_next) begin
            mismatch_next = 1'b1;
        end
        if (s1_last && (main_sum_next != target_next || anti_sum_next != target_next)) begin
            mismatch_next = 1'b1;
        end

        target_ext = EXT_W'(target_next);

        s1_valid_next = s_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);

        m_valid_next = m_valid_reg && !m_ready;
        if (s1_fire && s1_last) begin
            m_valid_next = 1'b1;
        end

        row_next = row_reg;
        col_next = col_reg;
        if (pos_flags.last_col) begin
            col_next = '0;
            row_next = pos_flags.last_row ? '0 : row_reg + IDX_W'(1);
        end else begin
            col_next = col_reg + IDX_W'(1);
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg    <= ORDER_WIDTH'(ORDER_RESET);
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                order_reg <= cfg_wr_data;
                row_reg   <= '0;
                col_reg   <= '0;
            end else if (s_accept) begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
        end
    end

    // Payload and accumulators.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_flags_reg <= pos_flags;
            s1_col_reg   <= col_reg;
            s1_value_reg <= ACC_W'(s_element_value);
            // The column written this cycle is the one being read: take the new sum.
            fwd_reg      <= s1_fire && (s1_col_reg == col_reg);
            fwd_data_reg <= col_new;
        end
        if (s1_fire) begin
            row_sum_reg  <= row_sum_next;
            target_reg   <= target_next;
            main_sum_reg <= main_sum_next;
            anti_sum_reg <= anti_sum_next;
            mismatch_reg <= mismatch_next;
            if (s1_last) begin
                m_is_magic_reg  <= !mismatch_next;
                m_magic_sum_reg <= target_ext[SUM_OUT_WIDTH-1:0];
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_is_magic  = m_is_magic_reg;
    assign m_magic_sum = m_magic_sum_reg;

endmodule

`default_nettype wire

/* sim/tb_magic_square_check.sv */
// Self-checking testbench for the magic square checker: directed squares, then random matrices.
`timescale 1ns / 1ps

module tb_magic_square_check;
    import msc_pkg::*;

    localparam int VW   = DEF_VALUE_WIDTH;
    localparam int MAXN = DEF_MAX_ORDER;
    localparam logic signed [VW-1:0] LO_SHU [9] = '{2, 7, 6, 9, 5, 1, 4, 3, 8};

    typedef enum int {MAT_MAGIC, MAT_PERTURBED, MAT_SWAPPED, MAT_RANDOM, MAT_FLAT}
        matrix_kind_t;

    typedef struct {
        logic                             is_magic;
        logic signed [SUM_OUT_WIDTH-1:0]  magic_sum;
    } verdict_t;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              cfg_wr_en = 1'b0;
    logic [ORDER_WIDTH-1:0]            cfg_wr_data = '0;
    logic                              s_valid = 1'b0;
    logic                              s_ready;
    logic signed [VW-1:0]              s_element_value = '0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic                              m_is_magic;
    logic signed [SUM_OUT_WIDTH-1:0]   m_magic_sum;

    // Elements waiting to be sent and verdicts waiting to arrive.
    logic signed [VW-1:0] elements_waiting [$];
    verdict_t             verdicts_due [$];

    // Predicted state of the checker.
    logic [ORDER_WIDTH-1:0] cur_order;
    int                     pos_row;
    int                     pos_col;
    int                     row_acc;
    int                     line_target;
    int                     col_acc [MAXN];
    int                     diag_acc;
    int                     anti_acc;
    bit                     line_broken;

    int  burst_left = 0;
    int  gap_left = 0;
    logic [31:0] ready_pat = '0;
    int  ready_left = 0;

    int  errors = 0;
    int  elements_sent = 0;
    int  verdicts_checked = 0;
    int  magic_seen = 0;
    int  settings_written = 0;

    magic_square_check u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_element_value (s_element_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_is_magic      (m_is_magic),
        .m_magic_sum     (m_magic_sum)
    );

    always #5 aclk = ~aclk;

    task automatic restart_tracking(input logic [ORDER_WIDTH-1:0] ord);
        cur_order   = ord;
        pos_row     = 0;
        pos_col     = 0;
        row_acc     = 0;
        line_target = 0;
        diag_acc    = 0;
        anti_acc    = 0;
        line_broken = 1'b0;
        foreach (col_acc[i]) col_acc[i] = 0;
    endtask

    // Folds one element into the line sums; at the last element of a matrix the
    // verdict is queued.
    task automatic accumulate_element(input logic signed [VW-1:0] value);
        int n;
        int r;
        int c;
        int v;
        verdict_t vd;
        n = (cur_order == 0) ? 1 : ((cur_order > MAXN) ? MAXN : int'(cur_order));
        r = pos_row;
        c = pos_col;
        v = value;
        if (r >= n || c >= n) begin
            r = 0;
            c = 0;
        end
        if (r == 0 && c == 0) begin
            diag_acc = 0;
            anti_acc = 0;
            line_broken = 1'b0;
        end
        row_acc = (c == 0) ? v : row_acc + v;
        col_acc[c] = (r == 0) ? v : col_acc[c] + v;
        if (r == c) diag_acc += v;
        if (c == n - 1 - r) anti_acc += v;
        if (c == n - 1) begin
            if (r == 0) line_target = row_acc;
            else if (row_acc != line_target) line_broken = 1'b1;
        end
        if (r == n - 1 && col_acc[c] != line_target) line_broken = 1'b1;
        if (r == n - 1 && c == n - 1) begin
            if (diag_acc != line_target || anti_acc != line_target) line_broken = 1'b1;
            vd.is_magic  = !line_broken;
            vd.magic_sum = line_target[SUM_OUT_WIDTH-1:0];
            verdicts_due.push_back(vd);
            pos_row = 0;
            pos_col = 0;
        end else if (c == n - 1) begin
            pos_row = r + 1;
            pos_col = 0;
        end else begin
            pos_row = r;
            pos_col = c + 1;
        end
    endtask

    // Waits until every element is sent and every verdict has arrived, then
    // idles so that the pipeline can empty.
    task automatic settle();
        do @(negedge aclk);
        while (elements_waiting.size() != 0 || s_valid || verdicts_due.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_order(input logic [ORDER_WIDTH-1:0] ord);
        settle();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ord;
        restart_tracking(ord);
        settings_written++;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Builds one matrix of order n and queues its first count elements.
    task automatic push_matrix(input int n, input matrix_kind_t kind, input int count);
        int base [MAXN][MAXN];
        int grid [MAXN][MAXN];
        int lim;
        int gain;
        int offset;
        int rr;
        int cc;
        int pr;
        int pc;
        int delta;
        int tmp;
        bit flip_r;
        bit flip_c;
        bit swap_rc;
        logic signed [VW-1:0] raw;
        lim     = 15000 / (n * n);
        gain    = int'($urandom_range(0, 2 * lim)) - lim;
        offset  = int'($urandom_range(0, 34000)) - 17000;
        flip_r  = 1'($urandom_range(0, 1));
        flip_c  = 1'($urandom_range(0, 1));
        swap_rc = 1'($urandom_range(0, 1));
        // Odd orders use the Siamese square, multiples of four the complement
        // pattern; other even orders only get a flat square.
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                if (n % 2 == 1) begin
                    base[r][c] = n * ((r + c + 1 + n / 2) % n) + ((r + 2 * c + 1) % n) + 1;
                end else if (n % 4 == 0) begin
                    base[r][c] = r * n + c + 1;
                    if ((r % 4 == c % 4) || ((r % 4) + (c % 4) == 3))
                        base[r][c] = n * n + 1 - base[r][c];
                end else begin
                    base[r][c] = 0;
                end
            end
        end
        // Any rotation or reflection of a magic square is still magic.
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                rr = swap_rc ? c : r;
                cc = swap_rc ? r : c;
                if (flip_r) rr = n - 1 - rr;
                if (flip_c) cc = n - 1 - cc;
                grid[r][c] = gain * base[rr][cc] + offset;
            end
        end
        case (kind)
            MAT_PERTURBED: begin
                pr = $urandom_range(0, n - 1);
                pc = $urandom_range(0, n - 1);
                delta = $urandom_range(1, 500);
                if ($urandom_range(0, 1)) delta = -delta;
                grid[pr][pc] += delta;
            end
            MAT_SWAPPED: begin
                // Row and column sums survive a column swap; the diagonals may not.
                if (n > 1) begin
                    pc = $urandom_range(1, n - 1);
                    for (int r = 0; r < n; r++) begin
                        tmp = grid[r][0];
                        grid[r][0] = grid[r][pc];
                        grid[r][pc] = tmp;
                    end
                end
            end
            MAT_RANDOM: begin
                for (int r = 0; r < n; r++) begin
                    for (int c = 0; c < n; c++) begin
                        raw = VW'($urandom);
                        grid[r][c] = raw;
                    end
                end
            end
            MAT_FLAT: begin
                case ($urandom_range(0, 2))
                    0: tmp = 32767;
                    1: tmp = -32768;
                    default: tmp = offset;
                endcase
                for (int r = 0; r < n; r++)
                    for (int c = 0; c < n; c++)
                        grid[r][c] = tmp;
            end
            default: ;
        endcase
        for (int i = 0; i < count; i++)
            elements_waiting.push_back(VW'(grid[i / n][i % n]));
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin : drive_elements
        logic take;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            take = s_valid && s_ready;
            if (take) begin
                accumulate_element(s_element_value);
                elements_sent++;
            end
            if (take || !s_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (elements_waiting.size() > 0) begin
                    s_valid         <= 1'b1;
                    s_element_value <= elements_waiting.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: a rotating stall pattern, reloaded with a new random one when its count runs out.
    always @(posedge aclk) begin : drive_ready
        if (ready_left == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pat = '1;
                1: ready_pat = $urandom;
                2: ready_pat = $urandom & $urandom;
                default: ready_pat = $urandom | $urandom;
            endcase
            ready_left = 64;
        end
        m_ready <= ready_pat[0];
        ready_pat = {ready_pat[0], ready_pat[31:1]};
        ready_left--;
    end

    always @(posedge aclk) begin : check_verdicts
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (verdicts_due.size() == 0) begin
                $error("verdict with none expected: is_magic %0d magic_sum %0d",
                       m_is_magic, m_magic_sum);
                errors++;
            end else begin
                want = verdicts_due.pop_front();
                verdicts_checked++;
                if (want.is_magic) magic_seen++;
                if (m_is_magic !== want.is_magic) begin
                    $error("is_magic: expected %0d, actual %0d", want.is_magic, m_is_magic);
                    errors++;
                end
                if (m_magic_sum !== want.magic_sum) begin
                    $error("magic_sum: expected %0d, actual %0d", want.magic_sum, m_magic_sum);
                    errors++;
                end
            end
        end
    end

    initial begin : stimulus
        int phase;
        int random_elements;
        int random_matrices;
        int n;
        int nmat;
        int cnt;
        int pick;
        logic [ORDER_WIDTH-1:0] ord;
        matrix_kind_t kind;
        restart_tracking(ORDER_WIDTH'(ORDER_RESET));
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Order after reset is three: the classic square of sum fifteen.
        foreach (LO_SHU[i]) elements_waiting.push_back(LO_SHU[i]);
        write_order(ORDER_WIDTH'(1));
        elements_waiting.push_back(16'h7fff);
        elements_waiting.push_back(16'h8000);
        // Order zero behaves as order one.
        write_order(ORDER_WIDTH'(0));
        elements_waiting.push_back(16'sd12345);
        // A partial matrix is dropped by the next register write.
        write_order(ORDER_WIDTH'(2));
        repeat (3) elements_waiting.push_back(16'h8000);
        write_order(ORDER_WIDTH'(2));
        repeat (4) elements_waiting.push_back(16'h8000);
        elements_waiting.push_back(16'sd1);
        elements_waiting.push_back(16'sd2);
        elements_waiting.push_back(16'sd3);
        elements_waiting.push_back(16'sd4);

        phase = 0;
        random_elements = 0;
        random_matrices = 0;
        while (random_elements < 750 || random_matrices < 60) begin
            if (phase == 0) begin
                ord = ORDER_WIDTH'(16);
            end else if (phase == 1) begin
                ord = ORDER_WIDTH'(31);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 5)       ord = ORDER_WIDTH'(0);
                else if (pick < 65) ord = ORDER_WIDTH'($urandom_range(1, 5));
                else if (pick < 85) ord = ORDER_WIDTH'($urandom_range(6, 9));
                else if (pick < 93) ord = ORDER_WIDTH'($urandom_range(10, 16));
                else                ord = ORDER_WIDTH'($urandom_range(17, 31));
            end
            write_order(ord);
            n = (ord == 0) ? 1 : ((ord > MAXN) ? MAXN : int'(ord));
            nmat = $urandom_range(1, (n * n >= 80) ? 1 : 80 / (n * n));
            repeat (nmat) begin
                pick = $urandom_range(0, 99);
                if (pick < 50)      kind = MAT_MAGIC;
                else if (pick < 65) kind = MAT_PERTURBED;
                else if (pick < 75) kind = MAT_SWAPPED;
                else if (pick < 90) kind = MAT_RANDOM;
                else                kind = MAT_FLAT;
                push_matrix(n, kind, n * n);
                random_elements += n * n;
                random_matrices++;
            end
            // Now and then leave an unfinished matrix for the next write to drop.
            if (n > 1 && $urandom_range(0, 3) == 0) begin
                cnt = $urandom_range(1, n * n - 1);
                push_matrix(n, MAT_MAGIC, cnt);
                random_elements += cnt;
            end
            phase++;
        end

        settle();
        $display("tb: %0d elements sent under %0d order settings", elements_sent,
                 settings_written);
        $display("tb: %0d verdicts checked, %0d of them magic", verdicts_checked, magic_seen);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
